// ----- rtl/wvm_pkg.sv -----
// Shared types, constants and the divider step function for the window-to-viewport mapper.
package wvm_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_CENTER_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DST_CENTER_Y = 3'd7;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // Result status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    // Quotient magnitude bits resolved by the divider and bits per stage.
    localparam int Q_BITS     = 34;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = Q_BITS / DIV_BITS;
    // Register stages of one axis datapath, from operand capture to saturated sum.
    localparam int AXIS_LAT   = DIV_STAGES + 7;

    localparam logic [Q_BITS-1:0]  Q_CLAMP = 34'h2_0000_0000;
    localparam logic signed [35:0] SUM_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SUM_MIN = -36'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic [1:0]         status;
    } t_out;

    // State carried through the restoring divider pipeline.
    typedef struct packed {
        logic [31:0]        rem;
        logic [Q_BITS-1:0]  dvd;
        logic [Q_BITS-1:0]  quo;
        logic [31:0]        dv;
        logic               sign;
        logic               big;
        logic signed [31:0] add;
    } t_div_st;

    // Resolves DIV_BITS quotient bits by restoring division.
    function automatic t_div_st wvm_div_step(input t_div_st s);
        t_div_st     o;
        logic [32:0] t;
        o = s;
        for (int i = 0; i < DIV_BITS; i++) begin
            t     = {o.rem, o.dvd[Q_BITS-1]};
            o.dvd = {o.dvd[Q_BITS-2:0], 1'b0};
            if (t >= {1'b0, o.dv}) begin
                o.rem = 32'(t - {1'b0, o.dv});
                o.quo = {o.quo[Q_BITS-2:0], 1'b1};
            end else begin
                o.rem = t[31:0];
                o.quo = {o.quo[Q_BITS-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/window_to_viewport_map.sv -----
// Path: a transaction accepted at a clock edge loads the first of the 24 datapath stages,
// and its result shows on o_data from the output register that follows the last of them.
// Throughput: one transaction per cycle while o_stall is low; the 17 divider stages of
// two quotient bits each set the depth. o_stall rises only when the output register and
// the skid stage are full.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module window_to_viewport_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  wvm_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output wvm_pkg::t_out                 o_data,
    input  logic                          i_cfg_we,
    input  logic [wvm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);
    import wvm_pkg::*;

    logic signed [31:0] r_src_width;
    logic signed [31:0] r_src_height;
    logic signed [31:0] r_src_center_x;
    logic signed [31:0] r_src_center_y;
    logic signed [31:0] r_dst_width;
    logic signed [31:0] r_dst_height;
    logic signed [31:0] r_dst_center_x;
    logic signed [31:0] r_dst_center_y;

    logic                   w_en;
    logic                   w_accept;
    logic signed [32:0]     w_diff_x;
    logic signed [32:0]     w_diff_y;
    logic [AXIS_LAT-1:0]    r_vld;
    logic [AXIS_LAT-1:0]    r_zero;
    logic signed [31:0]     w_res_x;
    logic signed [31:0]     w_res_y;
    logic                   w_sat_x;
    logic                   w_sat_y;
    t_out                   w_res;
    t_out                   r_out;
    logic                   r_out_v;
    t_out                   r_skid;
    logic                   r_skid_v;
    logic                   w_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= Q_ONE;
            r_src_height   <= Q_ONE;
            r_src_center_x <= '0;
            r_src_center_y <= '0;
            r_dst_width    <= Q_ONE;
            r_dst_height   <= Q_ONE;
            r_dst_center_x <= '0;
            r_dst_center_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_WIDTH:    r_src_width    <= i_cfg_data;
                REG_SRC_HEIGHT:   r_src_height   <= i_cfg_data;
                REG_SRC_CENTER_X: r_src_center_x <= i_cfg_data;
                REG_SRC_CENTER_Y: r_src_center_y <= i_cfg_data;
                REG_DST_WIDTH:    r_dst_width    <= i_cfg_data;
                REG_DST_HEIGHT:   r_dst_height   <= i_cfg_data;
                REG_DST_CENTER_X: r_dst_center_x <= i_cfg_data;
                REG_DST_CENTER_Y: r_dst_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the skid stage is empty.
    assign w_en     = !r_skid_v;
    assign o_stall  = r_skid_v;
    assign w_accept = i_valid && w_en;

    // The y difference is taken the other way round, which mirrors the y axis.
    assign w_diff_x = 33'(i_data.x_in) - 33'(r_src_center_x);
    assign w_diff_y = 33'(r_src_center_y) - 33'(i_data.y_in);

    wvm_axis u_axis_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_diff (w_diff_x),
        .i_mul  (r_dst_width),
        .i_div  (r_src_width),
        .i_add  (r_dst_center_x),
        .o_res  (w_res_x),
        .o_sat  (w_sat_x)
    );

    wvm_axis u_axis_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_diff (w_diff_y),
        .i_mul  (r_dst_height),
        .i_div  (r_src_height),
        .i_add  (r_dst_center_y),
        .o_res  (w_res_y),
        .o_sat  (w_sat_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[AXIS_LAT-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= {r_zero[AXIS_LAT-2:0], (r_src_width == '0) || (r_src_height == '0)};
        end
    end

    always_comb begin
        if (r_zero[AXIS_LAT-1]) begin
            w_res.x_out  = '0;
            w_res.y_out  = '0;
            w_res.status = STATUS_ZERO;
        end else begin
            w_res.x_out  = w_res_x;
            w_res.y_out  = w_res_y;
            w_res.status = (w_sat_x || w_sat_y) ? STATUS_SAT : STATUS_OK;
        end
    end

    // Output register with a skid stage behind it.
    assign w_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= r_vld[AXIS_LAT-1];
        end else if (r_vld[AXIS_LAT-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a transaction while the output register is empty");

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == STATUS_ZERO) |-> (o_data.x_out == '0 && o_data.y_out == '0))
        else $error("zero source size result carries non-zero coordinates");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == STATUS_OK || o_data.status == STATUS_ZERO ||
                     o_data.status == STATUS_SAT))
        else $error("undefined status code on output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall && r_vld[AXIS_LAT-1]))
        else $error("skid stage filled without a stalled output and a finished transaction");
`endif

endmodule

// ----- rtl/wvm_axis.sv -----
// One axis of the mapper: scale a centred coordinate by a ratio and add an offset, saturated.
module wvm_axis (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_diff,
    input  logic signed [31:0] i_mul,
    input  logic signed [31:0] i_div,
    input  logic signed [31:0] i_add,
    output logic signed [31:0] o_res,
    output logic               o_sat
);
    import wvm_pkg::*;

    logic signed [32:0] r_a1_diff;
    logic signed [31:0] r_a1_mul;
    logic signed [31:0] r_a1_div;
    logic signed [31:0] r_a1_add;

    logic [32:0]        r_a2_dmag;
    logic [31:0]        r_a2_mmag;
    logic [31:0]        r_a2_dvmag;
    logic               r_a2_sign;
    logic signed [31:0] r_a2_add;

    logic [48:0]        r_a3_lo;
    logic [47:0]        r_a3_hi;
    logic [31:0]        r_a3_dvmag;
    logic               r_a3_sign;
    logic signed [31:0] r_a3_add;

    logic [63:0]        r_a4_prod;
    logic [31:0]        r_a4_dvmag;
    logic               r_a4_sign;
    logic signed [31:0] r_a4_add;

    t_div_st            r_div [DIV_STAGES+1];
    t_div_st            n_div0;

    logic [Q_BITS-1:0]  w_mag;
    logic signed [34:0] r_fin_q;
    logic signed [31:0] r_fin_add;
    logic signed [35:0] w_sum;

    logic signed [31:0] r_res;
    logic               r_sat;

    // Operand capture.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1_diff <= i_diff;
            r_a1_mul  <= i_mul;
            r_a1_div  <= i_div;
            r_a1_add  <= i_add;
        end
    end

    // Magnitudes and sign of the quotient; the division truncates toward zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2_dmag  <= r_a1_diff[32] ? 33'(-r_a1_diff) : 33'(r_a1_diff);
            r_a2_mmag  <= r_a1_mul[31] ? 32'(-r_a1_mul) : 32'(r_a1_mul);
            r_a2_dvmag <= r_a1_div[31] ? 32'(-r_a1_div) : 32'(r_a1_div);
            r_a2_sign  <= r_a1_diff[32] ^ r_a1_mul[31] ^ r_a1_div[31];
            r_a2_add   <= r_a1_add;
        end
    end

    // Two partial products of the 33 by 32 bit magnitude product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a3_lo    <= {32'd0, r_a2_dmag[16:0]} * {17'd0, r_a2_mmag};
            r_a3_hi    <= {32'd0, r_a2_dmag[32:17]} * {16'd0, r_a2_mmag};
            r_a3_dvmag <= r_a2_dvmag;
            r_a3_sign  <= r_a2_sign;
            r_a3_add   <= r_a2_add;
        end
    end

    // The magnitude product never exceeds 2^63, so the top bit of the high part is zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a4_prod  <= {15'd0, r_a3_lo} + {r_a3_hi[46:0], 17'd0};
            r_a4_dvmag <= r_a3_dvmag;
            r_a4_sign  <= r_a3_sign;
            r_a4_add   <= r_a3_add;
        end
    end

    // A quotient of 2^34 or more is clamped anyway, so it is flagged here and only the
    // low 34 quotient bits are resolved.
    always_comb begin
        n_div0.big  = {2'd0, r_a4_prod[63:Q_BITS]} >= r_a4_dvmag;
        n_div0.rem  = n_div0.big ? 32'd0 : {2'd0, r_a4_prod[63:Q_BITS]};
        n_div0.dvd  = r_a4_prod[Q_BITS-1:0];
        n_div0.quo  = '0;
        n_div0.dv   = r_a4_dvmag;
        n_div0.sign = r_a4_sign;
        n_div0.add  = r_a4_add;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0] <= n_div0;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k] <= wvm_div_step(r_div[k-1]);
            end
        end
    end

    // Clamp the quotient to plus or minus 2^33 and apply the sign.
    assign w_mag = (r_div[DIV_STAGES].big || (r_div[DIV_STAGES].quo > Q_CLAMP)) ?
                   Q_CLAMP : r_div[DIV_STAGES].quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin_q   <= r_div[DIV_STAGES].sign ? -$signed({1'b0, w_mag})
                                                :  $signed({1'b0, w_mag});
            r_fin_add <= r_div[DIV_STAGES].add;
        end
    end

    assign w_sum = 36'(r_fin_q) + 36'(r_fin_add);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_sum > SUM_MAX) begin
                r_res <= SUM_MAX[31:0];
                r_sat <= 1'b1;
            end else if (w_sum < SUM_MIN) begin
                r_res <= SUM_MIN[31:0];
                r_sat <= 1'b1;
            end else begin
                r_res <= w_sum[31:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the window-to-viewport point mapper.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wvm_pkg::*;

    localparam logic signed [31:0] S32_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
    localparam longint             QUO_LIMIT  = 64'sd8589934592;
    localparam int                 DRAIN_WAIT = 40;
    localparam int                 IDLE_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_stall;
    t_in         in_data = '0;
    logic        o_valid;
    logic        out_stall = 1'b0;
    t_out        o_data;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    t_in                pending_q[$];
    t_out               expected_q[$];
    logic signed [31:0] cfg_reg[8];
    int                 error_count = 0;
    int                 send_gap = 0;
    int                 stall_left = 0;
    int                 src_mode = 0;
    int                 snk_mode = 0;
    int                 idle_cycles = 0;

    window_to_viewport_map u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (o_stall),
        .i_data     (in_data),
        .o_valid    (o_valid),
        .i_stall    (out_stall),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Scales one axis offset, with the quotient truncated toward zero and bounded so
    // that the later sum cannot wrap.
    function automatic longint scale_axis(longint diff, longint mul, longint div,
                                          longint add);
        longint quo;
        quo = (diff * mul) / div;
        if (quo > QUO_LIMIT) quo = QUO_LIMIT;
        if (quo < -QUO_LIMIT) quo = -QUO_LIMIT;
        return quo + add;
    endfunction

    function automatic logic signed [31:0] clamp_s32(longint v, inout bit sat);
        if (v > longint'(S32_MAX)) begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < longint'(S32_MIN)) begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_out map_point(t_in p);
        t_out   res;
        bit     sat;
        longint xr;
        longint yr;
        res = '0;
        sat = 1'b0;
        if (cfg_reg[REG_SRC_WIDTH] == 0 || cfg_reg[REG_SRC_HEIGHT] == 0) begin
            res.status = STATUS_ZERO;
            return res;
        end
        xr = scale_axis(longint'(p.x_in) - longint'(cfg_reg[REG_SRC_CENTER_X]),
                        longint'(cfg_reg[REG_DST_WIDTH]), longint'(cfg_reg[REG_SRC_WIDTH]),
                        longint'(cfg_reg[REG_DST_CENTER_X]));
        // The y axis is mirrored, so the offset is taken the other way round.
        yr = scale_axis(longint'(cfg_reg[REG_SRC_CENTER_Y]) - longint'(p.y_in),
                        longint'(cfg_reg[REG_DST_HEIGHT]), longint'(cfg_reg[REG_SRC_HEIGHT]),
                        longint'(cfg_reg[REG_DST_CENTER_Y]));
        res.x_out  = clamp_s32(xr, sat);
        res.y_out  = clamp_s32(yr, sat);
        res.status = sat ? STATUS_SAT : STATUS_OK;
        return res;
    endfunction

    function automatic int pick_idle(int mode);
        int r;
        if (mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < (mode == 1 ? 75 : 40)) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_size();
        int r;
        r = $urandom_range(0, 39);
        case (r)
            0: return '0;
            1: return S32_MIN;
            2: return S32_MAX;
            3: return 32'sd1;
            4: return -32'sd1;
            5, 6, 7, 8: return $urandom;
            default: begin
                if ($urandom_range(0, 1)) return $urandom_range(4096, 4194304);
                return -$signed($urandom_range(4096, 4194304));
            end
        endcase
    endfunction

    function automatic logic signed [31:0] rand_centre();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return S32_MIN;
            1: return S32_MAX;
            2, 3, 4: return $urandom;
            default: begin
                if ($urandom_range(0, 1)) return $urandom_range(0, 1 << 24);
                return -$signed($urandom_range(0, 1 << 24));
            end
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord(logic signed [31:0] centre);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0: return S32_MIN;
                    1: return S32_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $urandom;
            default: begin
                if ($urandom_range(0, 1)) return centre + $urandom_range(0, 1 << 22);
                return centre - $urandom_range(0, 1 << 22);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic push_point(logic signed [31:0] x, logic signed [31:0] y);
        t_in p;
        p.x_in = x;
        p.y_in = y;
        pending_q.push_back(p);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_reg[idx] = val;
    endtask

    task automatic load_map(logic signed [31:0] sw, logic signed [31:0] sh,
                            logic signed [31:0] scx, logic signed [31:0] scy,
                            logic signed [31:0] dw, logic signed [31:0] dh,
                            logic signed [31:0] dcx, logic signed [31:0] dcy);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_SRC_CENTER_X, scx);
        write_reg(REG_SRC_CENTER_Y, scy);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_DST_CENTER_X, dcx);
        write_reg(REG_DST_CENTER_Y, dcy);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Returns once every queued point has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Point driver.
    always @(posedge i_clk) begin
        if (in_valid && !o_stall)
            expected_q.push_back(map_point(in_data));
        if (in_valid && o_stall) begin
            // The payload is held until the pipeline accepts it.
        end else if (send_gap > 0) begin
            in_valid <= 1'b0;
            send_gap--;
        end else if (pending_q.size() != 0) begin
            in_data  <= pending_q.pop_front();
            in_valid <= 1'b1;
            send_gap = pick_idle(src_mode);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Result monitor and downstream stall generator.
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding",
                                    o_data.x_out, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.x_out !== want.x_out)
                        report_mismatch("x_out", o_data.x_out, want.x_out);
                    if (o_data.y_out !== want.y_out)
                        report_mismatch("y_out", o_data.y_out, want.y_out);
                    if (o_data.status !== want.status)
                        report_mismatch("status", 32'(o_data.status), 32'(want.status));
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_idle(snk_mode);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("window_to_viewport_map regression: fail");
            $finish;
        end
    end

    initial begin
        cfg_reg[REG_SRC_WIDTH]    = Q_ONE;
        cfg_reg[REG_SRC_HEIGHT]   = Q_ONE;
        cfg_reg[REG_SRC_CENTER_X] = '0;
        cfg_reg[REG_SRC_CENTER_Y] = '0;
        cfg_reg[REG_DST_WIDTH]    = Q_ONE;
        cfg_reg[REG_DST_HEIGHT]   = Q_ONE;
        cfg_reg[REG_DST_CENTER_X] = '0;
        cfg_reg[REG_DST_CENTER_Y] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Identity mapping after reset: field extremes and the mirrored y axis.
        push_point(32'sd0, 32'sd0);
        push_point(S32_MAX, S32_MAX);
        push_point(S32_MIN, S32_MIN);
        push_point(S32_MAX, S32_MIN);
        push_point(S32_MIN, S32_MAX);
        push_point(Q_ONE, -Q_ONE);
        push_point(-32'sd1, 32'sd1);
        push_point(32'sh1234_5678, 32'sh9abc_def0);
        wait_drained();

        // Zero source width, then zero source height.
        write_reg(REG_SRC_WIDTH, '0);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        push_point(S32_MAX, S32_MIN);
        push_point(32'sd1, 32'sd1);
        wait_drained();
        write_reg(REG_SRC_WIDTH, Q_ONE);
        write_reg(REG_SRC_HEIGHT, '0);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        push_point(S32_MIN, S32_MAX);
        push_point(-32'sd1, 32'sd0);
        wait_drained();

        // Extreme registers: huge quotients and saturation in both directions.
        load_map(32'sd1, -32'sd1, S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
        push_point(S32_MAX, S32_MIN);
        push_point(S32_MIN, S32_MAX);
        push_point(32'sd0, 32'sd0);
        push_point(S32_MIN, S32_MIN);
        wait_drained();

        // Negative sizes mirror the axis; odd ratios exercise truncation toward zero.
        load_map(-2 * Q_ONE, 3 * Q_ONE, 32'sd100, -32'sd100, Q_ONE, -Q_ONE,
                 32'sd7, -32'sd7);
        push_point(32'sd3, -32'sd5);
        push_point(-32'sd3, 32'sd7);
        push_point(Q_ONE + 1, -Q_ONE - 1);
        push_point(32'sd0, 32'sd0);
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            src_mode = (phase % 3 == 0) ? 0 : $urandom_range(1, 2);
            snk_mode = (phase % 4 == 1) ? 0 : $urandom_range(1, 2);
            load_map(rand_size(), rand_size(), rand_centre(), rand_centre(),
                     rand_size(), rand_size(), rand_centre(), rand_centre());
            for (int n = 0; n < 150; n++) begin
                push_point(rand_coord(cfg_reg[REG_SRC_CENTER_X]),
                           rand_coord(cfg_reg[REG_SRC_CENTER_Y]));
                // Halfway through one phase the sender holds off until the pipeline empties.
                if (phase == 5 && n == 74)
                    wait_drained();
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("window_to_viewport_map regression: pass");
        else
            $display("window_to_viewport_map regression: fail");
        $finish;
    end

endmodule
